// File: src/tcpu_pkg.sv
// Shared types and constants of the teaching CPU execute unit.
`timescale 1ns / 1ps
package tcpu_pkg;

   localparam int DMEM_BYTES_DEF = 4096;
   localparam int GP_REGS        = 5;

   // request kinds
   localparam logic [1:0] RT_EXEC = 2'd0;
   localparam logic [1:0] RT_LOAD = 2'd1;
   localparam logic [1:0] RT_READ = 2'd2;

   // opcodes
   localparam logic [4:0] OP_LOAD = 5'd0;
   localparam logic [4:0] OP_MULR = 5'd1;
   localparam logic [4:0] OP_ADDR = 5'd2;
   localparam logic [4:0] OP_DECR = 5'd3;
   localparam logic [4:0] OP_DIVR = 5'd4;
   localparam logic [4:0] OP_MODR = 5'd5;
   localparam logic [4:0] OP_SUBR = 5'd6;
   localparam logic [4:0] OP_INCR = 5'd7;
   localparam logic [4:0] OP_XXXX = 5'd8;
   localparam logic [4:0] OP_GETM = 5'd9;
   localparam logic [4:0] OP_SETM = 5'd10;
   localparam logic [4:0] OP_MOVR = 5'd11;
   localparam logic [4:0] OP_COMP = 5'd12;
   localparam logic [4:0] OP_CGEQ = 5'd13;
   localparam logic [4:0] OP_CLEQ = 5'd14;
   localparam logic [4:0] OP_GOTO = 5'd15;
   localparam logic [4:0] OP_JMPZ = 5'd16;
   localparam logic [4:0] OP_JPNZ = 5'd17;
   localparam logic [4:0] OP_INTE = 5'd18;
   localparam logic [4:0] OP_SHIF = 5'd19;
   localparam logic [4:0] OP_NOPP = 5'd20;
   localparam logic [4:0] OP_PUSH = 5'd21;
   localparam logic [4:0] OP_TAKE = 5'd22;
   localparam logic [4:0] OP_MALC = 5'd23;

   // register codes
   localparam logic [3:0] RC_A  = 4'd0;
   localparam logic [3:0] RC_B  = 4'd1;
   localparam logic [3:0] RC_C  = 4'd2;
   localparam logic [3:0] RC_D  = 4'd3;
   localparam logic [3:0] RC_E  = 4'd4;
   localparam logic [3:0] RC_CB = 4'd5;
   localparam logic [3:0] RC_IP = 4'd6;
   localparam logic [3:0] RC_SB = 4'd7;
   localparam logic [3:0] RC_SC = 4'd8;

   // status codes
   localparam logic [2:0] ST_OK   = 3'd0;
   localparam logic [2:0] ST_DIVZ = 3'd1;
   localparam logic [2:0] ST_HALT = 3'd2;
   localparam logic [2:0] ST_INT  = 3'd3;
   localparam logic [2:0] ST_PRIV = 3'd4;
   localparam logic [2:0] ST_MEMF = 3'd5;
   localparam logic [2:0] ST_CNT  = 3'd6;
   localparam logic [2:0] ST_SVC  = 3'd7;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [4:0]  opcode;
      logic [3:0]  reg_first;
      logic [3:0]  reg_second;
      logic [31:0] immediate;
      logic        is_div;
      logic        is_mem;
      logic        is_prot;
   } item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] reg_value;
      logic [31:0] next_pointer;
      logic [31:0] service_arg;
      logic        running;
   } resp_type;

endpackage

// File: src/teaching_cpu_execute_unit.sv
// Top level of the teaching CPU execute unit.
// After reset the unit sweeps its data memory to zero, one byte per cycle,
// and takes no request meanwhile. A request then passes a two-entry queue
// into the back end. Register, ALU, jump and control requests, divide by zero,
// bad counts and memory faults go from S_EXEC straight to S_POST. DIVR and MODR
// run a 32-step restoring divider (S_DIV, then S_DIVFIN). Memory stores write
// one byte per S_WR state; memory loads pass S_RDI and S_RDC for each byte,
// then S_RDFIN (one RAM port, registered read). S_POST waits until the response
// register is free. One request is in the back end at a time; the queue and
// the response register let the front accept and the output wait meanwhile.
`timescale 1ns / 1ps
module teaching_cpu_execute_unit #(
   parameter int DMEM_BYTES = tcpu_pkg::DMEM_BYTES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data,    // kernel_mode
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,      // req_type
   input  logic [47:0]  req_tdata,      // opcode, reg_first, reg_second, immediate
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [2:0]   rsp_tuser,      // status
   output logic [103:0] rsp_tdata       // reg_value, next_pointer, service_arg, running
);
   import tcpu_pkg::*;

   logic     kernel_ff;
   logic     q_valid, q_pop, clr_busy;
   item_type q_item;
   resp_type rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_ff <= 1'b0;
      end else if (csr_wr_en) begin
         kernel_ff <= csr_wr_data;
      end
   end

   tcpu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept_en  (!clr_busy),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   tcpu_back #(.DMEM_BYTES(DMEM_BYTES)) u_back (
      .clock       (clock),
      .reset       (reset),
      .kernel_mode (kernel_ff),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop),
      .clr_busy    (clr_busy),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp         (rsp)
   );

   assign rsp_tuser = rsp.status;
   assign rsp_tdata = {7'd0, rsp.running, rsp.service_arg, rsp.next_pointer, rsp.reg_value};

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty request queue");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      clr_busy |-> !req_tready) else $error("request accepted during memory clear");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> !q_pop) else $error("back end took two requests in a row");
endmodule

// File: src/tcpu_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module tcpu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;
endmodule

// File: src/tcpu_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module tcpu_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept_en,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [1:0]        req_tuser,
   input  logic [47:0]       req_tdata,
   output logic              q_valid,
   output tcpu_pkg::item_type q_item,
   input  logic              q_pop
);
   import tcpu_pkg::*;

   item_type   slot_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;
   item_type   new_item;
   logic       push;

   always_comb begin
      new_item.req_type   = req_tuser;
      new_item.opcode     = req_tdata[4:0];
      new_item.reg_first  = req_tdata[8:5];
      new_item.reg_second = req_tdata[12:9];
      new_item.immediate  = req_tdata[44:13];
      new_item.is_div     = (req_tdata[4:0] == OP_DIVR) || (req_tdata[4:0] == OP_MODR);
      new_item.is_mem     = (req_tdata[4:0] == OP_GETM) || (req_tdata[4:0] == OP_SETM) ||
                            (req_tdata[4:0] == OP_PUSH) || (req_tdata[4:0] == OP_TAKE);
      new_item.is_prot    = (req_tdata[4:0] >= OP_MALC);
   end

   assign req_tready = accept_en && (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign q_item     = slot_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff ^ push;
      rptr_in  = rptr_ff ^ q_pop;
      count_in = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wptr_ff] <= new_item;
      end
   end
endmodule

// File: src/tcpu_back.sv
// Back end: register file, ALU, iterative divider, memory sequencer and response register.
`timescale 1ns / 1ps
module tcpu_back #(
   parameter int DMEM_BYTES = tcpu_pkg::DMEM_BYTES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               kernel_mode,
   input  logic               q_valid,
   input  tcpu_pkg::item_type q_item,
   output logic               q_pop,
   output logic               clr_busy,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output tcpu_pkg::resp_type rsp
);
   import tcpu_pkg::*;

   localparam int AW = $clog2(DMEM_BYTES);

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_EXEC   = 4'd2;
   localparam logic [3:0] S_DIV    = 4'd3;
   localparam logic [3:0] S_DIVFIN = 4'd4;
   localparam logic [3:0] S_WR     = 4'd5;
   localparam logic [3:0] S_RDI    = 4'd6;
   localparam logic [3:0] S_RDC    = 4'd7;
   localparam logic [3:0] S_RDFIN  = 4'd8;
   localparam logic [3:0] S_POST   = 4'd9;

   logic [3:0]                 state_ff, state_in;
   item_type                   item_ff, item_in;
   logic [GP_REGS-1:0][31:0]   gp_ff, gp_in;
   logic [31:0]                cb_ff, cb_in, ip_ff, ip_in, sb_ff, sb_in, sc_ff, sc_in;
   logic                       run_ff, run_in;
   logic [AW-1:0]              clr_ff, clr_in;
   logic [AW-1:0]              base_ff, base_in;
   logic [1:0]                 idx_ff, idx_in, last_ff, last_in;
   logic [31:0]                data_ff, data_in;
   logic [3:0][7:0]            acc_ff, acc_in;
   logic [31:0]                rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic [4:0]                 dcnt_ff, dcnt_in;
   logic [2:0]                 status_ff, status_in;
   logic [31:0]                rv_ff, rv_in, svc_ff, svc_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   resp_type                   rsp_ff, rsp_in;

   logic [31:0] a_val, b_val, imm, mem_base, wr_shift, shift_res, div_res;
   logic [32:0] mem_len, trial;
   logic        cnt_ok, mem_ok;
   logic [4:0]  shamt;
   logic        wr_en, sc_adj, clr, run_set, ip_set;
   logic [3:0]  wr_code;
   logic [31:0] wr_data, sc_delta, ip_val;
   logic        ram_we;
   logic [AW-1:0] ram_addr;
   logic [7:0]  ram_wdata, ram_rdata;

   function automatic logic [31:0] rd_reg(input logic [3:0] code,
                                          input logic [GP_REGS-1:0][31:0] gp,
                                          input logic [31:0] cb, input logic [31:0] ip,
                                          input logic [31:0] sb, input logic [31:0] sc);
      logic [31:0] v;
      unique case (code)
         RC_A:    v = gp[0];
         RC_B:    v = gp[1];
         RC_C:    v = gp[2];
         RC_D:    v = gp[3];
         RC_E:    v = gp[4];
         RC_CB:   v = cb;
         RC_IP:   v = ip;
         RC_SB:   v = sb;
         RC_SC:   v = sc;
         default: v = 32'hFFFF_FFFF;
      endcase
      return v;
   endfunction

   tcpu_ram #(.WIDTH(8), .DEPTH(DMEM_BYTES)) u_dmem (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   always_comb begin
      imm   = item_ff.immediate;
      a_val = rd_reg(item_ff.reg_first, gp_ff, cb_ff, ip_ff, sb_ff, sc_ff);
      b_val = rd_reg(item_ff.reg_second, gp_ff, cb_ff, ip_ff, sb_ff, sc_ff);
      cnt_ok = (imm >= 32'd1) && (imm <= 32'd4);
      priority case (item_ff.opcode)
         OP_GETM: mem_base = b_val;
         OP_SETM: mem_base = a_val;
         OP_PUSH: mem_base = sc_ff;
         default: mem_base = sc_ff - imm;
      endcase
      mem_len = (item_ff.opcode == OP_GETM) ? 33'd1 : {1'b0, imm};
      mem_ok  = !mem_base[31] && (({1'b0, mem_base} + mem_len) <= 33'(DMEM_BYTES));
      shamt   = (imm[31:5] != 27'd0) ? 5'd31 : imm[4:0];
      shift_res = 32'($signed(a_val) >>> shamt);
      wr_shift  = data_ff >> {idx_ff, 3'b000};
      trial     = {rem_ff, quo_ff[31]} - {1'b0, dvs_ff};
      if (item_ff.opcode == OP_DIVR) begin
         div_res = (a_val[31] ^ b_val[31]) ? (32'd0 - quo_ff) : quo_ff;
      end else begin
         div_res = a_val[31] ? (32'd0 - rem_ff) : rem_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      gp_in        = gp_ff;
      cb_in        = cb_ff;
      ip_in        = ip_ff;
      sb_in        = sb_ff;
      sc_in        = sc_ff;
      run_in       = run_ff;
      clr_in       = clr_ff;
      base_in      = base_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      data_in      = data_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dvs_in       = dvs_ff;
      dcnt_in      = dcnt_ff;
      status_in    = status_ff;
      rv_in        = rv_ff;
      svc_in       = svc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      wr_en    = 1'b0;
      wr_code  = item_ff.reg_first;
      wr_data  = 32'd0;
      sc_adj   = 1'b0;
      sc_delta = 32'd0;
      clr      = 1'b0;
      run_set  = 1'b0;
      ip_set   = 1'b0;
      ip_val   = 32'd0;
      ram_we    = 1'b0;
      ram_addr  = base_ff + AW'(idx_ff);
      ram_wdata = wr_shift[7:0];
      q_pop     = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_addr  = clr_ff;
            ram_wdata = 8'd0;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(DMEM_BYTES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               item_in  = q_item;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            status_in = ST_OK;
            rv_in     = 32'd0;
            svc_in    = 32'd0;
            state_in  = S_POST;
            acc_in    = '0;
            idx_in    = 2'd0;
            base_in   = mem_base[AW-1:0];
            last_in   = (item_ff.opcode == OP_GETM) ? 2'd0 : 2'(imm - 32'd1);
            unique case (item_ff.req_type)
               RT_LOAD: begin
                  wr_en   = 1'b1;
                  wr_data = imm;
                  run_set = 1'b1;
               end
               RT_READ: rv_in = a_val;
               RT_EXEC: begin
                  priority if (item_ff.is_prot) begin
                     if (kernel_mode) begin
                        status_in = ST_SVC;
                     end else begin
                        status_in = ST_PRIV;
                        clr       = 1'b1;
                     end
                  end else if (item_ff.is_div) begin
                     if (b_val == 32'd0) begin
                        status_in = ST_DIVZ;
                     end else begin
                        rem_in   = 32'd0;
                        quo_in   = a_val[31] ? (32'd0 - a_val) : a_val;
                        dvs_in   = b_val[31] ? (32'd0 - b_val) : b_val;
                        dcnt_in  = 5'd0;
                        state_in = S_DIV;
                     end
                  end else if (item_ff.is_mem) begin
                     if ((item_ff.opcode != OP_GETM) && !cnt_ok) begin
                        status_in = ST_CNT;
                     end else if (!mem_ok) begin
                        status_in = ST_MEMF;
                     end else if (item_ff.opcode == OP_SETM) begin
                        data_in  = b_val;
                        state_in = S_WR;
                     end else if (item_ff.opcode == OP_PUSH) begin
                        data_in  = a_val;
                        state_in = S_WR;
                     end else begin
                        state_in = S_RDI;
                     end
                  end else begin
                     unique case (item_ff.opcode)
                        OP_LOAD: begin
                           wr_en = 1'b1; wr_data = imm;
                        end
                        OP_MULR: begin
                           wr_en = 1'b1; wr_code = RC_A; wr_data = 32'(a_val * b_val);
                        end
                        OP_ADDR: begin
                           wr_en = 1'b1; wr_code = RC_A; wr_data = a_val + b_val;
                        end
                        OP_SUBR: begin
                           wr_en = 1'b1; wr_code = RC_A; wr_data = a_val - b_val;
                        end
                        OP_DECR: begin
                           wr_en = 1'b1; wr_data = a_val - 32'd1;
                        end
                        OP_INCR: begin
                           wr_en = 1'b1; wr_data = a_val + 32'd1;
                        end
                        OP_MOVR: begin
                           wr_en = 1'b1; wr_data = b_val;
                        end
                        OP_COMP: begin
                           wr_en = 1'b1; wr_code = RC_A;
                           wr_data = {31'd0, a_val == b_val};
                        end
                        OP_CGEQ: begin
                           wr_en = 1'b1; wr_code = RC_A;
                           wr_data = {31'd0, !($signed(a_val) < $signed(b_val))};
                        end
                        OP_CLEQ: begin
                           wr_en = 1'b1; wr_code = RC_A;
                           wr_data = {31'd0, !($signed(b_val) < $signed(a_val))};
                        end
                        OP_GOTO: begin
                           ip_set = 1'b1; ip_val = cb_ff + a_val;
                        end
                        OP_JMPZ: begin
                           ip_set = (gp_ff[0] == 32'd0); ip_val = cb_ff + imm;
                        end
                        OP_JPNZ: begin
                           ip_set = (gp_ff[0] != 32'd0); ip_val = cb_ff + imm;
                        end
                        OP_SHIF: begin
                           wr_en = 1'b1; wr_data = shift_res;
                        end
                        OP_XXXX: begin
                           clr = 1'b1; status_in = ST_HALT;
                        end
                        OP_INTE: begin
                           clr = 1'b1; status_in = ST_INT; svc_in = imm;
                        end
                        default: ;
                     endcase
                  end
               end
               default: ;
            endcase
         end
         S_DIV: begin
            if (!trial[32]) begin
               rem_in = trial[31:0];
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = {rem_ff[30:0], quo_ff[31]};
               quo_in = {quo_ff[30:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 5'd1;
            if (dcnt_ff == 5'd31) begin
               state_in = S_DIVFIN;
            end
         end
         S_DIVFIN: begin
            wr_en    = 1'b1;
            wr_code  = RC_A;
            wr_data  = div_res;
            state_in = S_POST;
         end
         S_WR: begin
            ram_we = 1'b1;
            idx_in = idx_ff + 2'd1;
            if (idx_ff == last_ff) begin
               if (item_ff.opcode == OP_PUSH) begin
                  sc_adj   = 1'b1;
                  sc_delta = imm;
               end
               state_in = S_POST;
            end
         end
         S_RDI: state_in = S_RDC;
         S_RDC: begin
            acc_in[idx_ff] = ram_rdata;
            idx_in         = idx_ff + 2'd1;
            state_in       = (idx_ff == last_ff) ? S_RDFIN : S_RDI;
         end
         S_RDFIN: begin
            wr_en = 1'b1;
            if (item_ff.opcode == OP_GETM) begin
               wr_data = {{24{acc_ff[0][7]}}, acc_ff[0]};
            end else begin
               wr_data  = acc_ff;
               sc_adj   = 1'b1;
               sc_delta = 32'd0 - imm;
            end
            state_in = S_POST;
         end
         S_POST: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in        = 1'b1;
               rsp_in.status       = status_ff;
               rsp_in.reg_value    = rv_ff;
               rsp_in.next_pointer = ip_ff;
               rsp_in.service_arg  = svc_ff;
               rsp_in.running      = run_ff;
               state_in            = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (wr_en) begin
         unique case (wr_code)
            RC_A:    gp_in[0] = wr_data;
            RC_B:    gp_in[1] = wr_data;
            RC_C:    gp_in[2] = wr_data;
            RC_D:    gp_in[3] = wr_data;
            RC_E:    gp_in[4] = wr_data;
            RC_CB:   cb_in = wr_data;
            RC_IP:   ip_in = wr_data;
            RC_SB:   sb_in = wr_data;
            RC_SC:   sc_in = wr_data;
            default: ;
         endcase
      end
      // take: cursor moves after the destination write
      if (sc_adj) begin
         sc_in = sc_in + sc_delta;
      end
      if (ip_set) begin
         ip_in = ip_val;
      end
      if (run_set) begin
         run_in = 1'b1;
      end
      if (clr) begin
         gp_in  = '0;
         cb_in  = 32'd0;
         ip_in  = 32'd0;
         sb_in  = 32'd0;
         sc_in  = 32'd0;
         run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         gp_ff        <= '0;
         cb_ff        <= 32'd0;
         ip_ff        <= 32'd0;
         sb_ff        <= 32'd0;
         sc_ff        <= 32'd0;
         run_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         gp_ff        <= gp_in;
         cb_ff        <= cb_in;
         ip_ff        <= ip_in;
         sb_ff        <= sb_in;
         sc_ff        <= sc_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff   <= item_in;
      base_ff   <= base_in;
      idx_ff    <= idx_in;
      last_ff   <= last_in;
      data_ff   <= data_in;
      acc_ff    <= acc_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      dvs_ff    <= dvs_in;
      dcnt_ff   <= dcnt_in;
      status_ff <= status_in;
      rv_ff     <= rv_in;
      svc_ff    <= svc_in;
      rsp_ff    <= rsp_in;
   end

   assign clr_busy  = (state_ff == S_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
endmodule
